### hw/rtl/ysub_pkg.sv
// Package for the 4:4:4 to 4:2:0 chroma subsampler.
// Holds sizes, codes and the structs shared by the ysub_* modules; no dependencies.
`default_nettype none

package ysub_pkg;

  // Frame geometry
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  localparam int unsigned POS_W      = 12;  // row and column counters
  localparam int unsigned DIM_W      = 13;  // width and height registers
  localparam int unsigned SUM_W      = 9;   // sum of two 8-bit samples
  localparam int unsigned PAIR_W     = 2 * SUM_W;

  localparam logic [DIM_W-1:0] WIDTH_MIN   = DIM_W'(2);
  localparam logic [DIM_W-1:0] WIDTH_MAX   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MIN  = DIM_W'(1);
  localparam logic [DIM_W-1:0] HEIGHT_MAX  = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] WIDTH_RST   = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RST  = DIM_W'(1080);

  // Configuration register indexes
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHROMA_LAYOUT = 2'd2;

  // Chroma layouts
  localparam logic LAYOUT_NV12 = 1'b0;
  localparam logic LAYOUT_I420 = 1'b1;

  // Output plane codes
  localparam logic [1:0] PLANE_Y  = 2'd0;
  localparam logic [1:0] PLANE_UV = 2'd1;  // also the U plane in I420
  localparam logic [1:0] PLANE_V  = 2'd2;

  // Emitter step codes
  localparam logic [1:0] STEP_LUMA = 2'd0;
  localparam logic [1:0] STEP_CB   = 2'd1;
  localparam logic [1:0] STEP_CR   = 2'd2;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic             layout;
  } cfg_t;

  // One pixel after the front stage
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [7:0]       luma;
    logic [SUM_W-1:0] cbs;
    logic [SUM_W-1:0] crs;
    logic             chroma;  // completes a 2x2 block
    logic             layout;
  } item_t;

endpackage

`default_nettype wire

### hw/rtl/ysub_in_if.sv
// Pixel request channel: valid/ready with the three packed 4:4:4 bytes.
// No dependencies.
`default_nettype none

interface ysub_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cb_in;
  logic [7:0] luma_in;
  logic [7:0] cr_in;

  modport source (output valid, cb_in, luma_in, cr_in, input ready);
  modport sink   (input valid, cb_in, luma_in, cr_in, output ready);
endinterface

`default_nettype wire

### hw/rtl/ysub_out_if.sv
// Result request channel: valid/ready with one plane byte and its position.
// No dependencies.
`default_nettype none

interface ysub_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  plane;
  logic [11:0] out_row;
  logic [11:0] out_column;
  logic [7:0]  sample;
  logic        last;

  modport source (output valid, plane, out_row, out_column, sample, last, input ready);
  modport sink   (input valid, plane, out_row, out_column, sample, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/ysub_cfg.sv
// APB register file: line width, frame height, chroma layout, and their clamped values.
// Depends on ysub_pkg.
`default_nettype none

module ysub_cfg
  import ysub_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             layout_r;
  logic [1:0]       reg_idx;
  logic             wr_en;
  logic [DIM_W-1:0] w_clamp;
  logic [DIM_W-1:0] h_clamp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      layout_r <= LAYOUT_NV12;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LINE_WIDTH:    width_r  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:  height_r <= pwdata[DIM_W-1:0];
        REG_CHROMA_LAYOUT: layout_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_LINE_WIDTH:    prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_FRAME_HEIGHT:  prdata = {{(32-DIM_W){1'b0}}, height_r};
      REG_CHROMA_LAYOUT: prdata = {31'd0, layout_r};
      default:           prdata = 32'd0;
    endcase
  end

  // Clamp to the supported range; width is forced even
  always_comb begin
    w_clamp = width_r;
    if (w_clamp < WIDTH_MIN) w_clamp = WIDTH_MIN;
    if (w_clamp > WIDTH_MAX) w_clamp = WIDTH_MAX;
    h_clamp = height_r;
    if (h_clamp < HEIGHT_MIN) h_clamp = HEIGHT_MIN;
    if (h_clamp > HEIGHT_MAX) h_clamp = HEIGHT_MAX;
    cfg.eff_w  = {w_clamp[DIM_W-1:1], 1'b0};
    cfg.eff_h  = h_clamp;
    cfg.layout = layout_r;
  end

endmodule

`default_nettype wire

### hw/rtl/ysub_line_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module ysub_line_ram #(
  parameter int unsigned DW = 18,
  parameter int unsigned AW = 11
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic [DW-1:0]      rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ysub_front.sv
// Front stage: row/column counters, held even-column chroma, line store access.
// Depends on ysub_pkg and ysub_in_if; drives ysub_line_ram.
`default_nettype none

module ysub_front
  import ysub_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  ysub_in_if.sink          in_px,
  // line store port
  output logic             ram_wr_en,
  output logic             ram_rd_en,
  output logic [LINE_AW-1:0] ram_addr,
  output logic [PAIR_W-1:0]  ram_wdata,
  // to the emitter
  output logic             s1_valid,
  output item_t            s1_item,
  input  wire logic        s1_take
);

  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [15:0]      held_r, held_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r, s1_item_nxt;

  logic             accept;
  logic [DIM_W-1:0] w_last, h_last;
  logic [POS_W-1:0] col_c, row_c;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic [SUM_W-1:0] cbs, crs;

  assign in_px.ready = !s1_valid_r || s1_take;
  assign accept      = in_px.valid && in_px.ready;
  assign s1_valid    = s1_valid_r;
  assign s1_item     = s1_item_r;

  // Position of this pixel, pulled inside a shrunken frame
  always_comb begin
    w_last  = cfg.eff_w - DIM_W'(1);
    h_last  = cfg.eff_h - DIM_W'(1);
    col_c   = ({1'b0, col_r} >= cfg.eff_w) ? w_last[POS_W-1:0] : col_r;
    row_c   = ({1'b0, row_r} >= cfg.eff_h) ? h_last[POS_W-1:0] : row_r;
    col_inc = {1'b0, col_c} + DIM_W'(1);
    row_inc = {1'b0, row_c} + DIM_W'(1);
    cbs     = {1'b0, held_r[7:0]}  + {1'b0, in_px.cb_in};
    crs     = {1'b0, held_r[15:8]} + {1'b0, in_px.cr_in};
  end

  // Line store: even rows write the pair sums, odd rows read them back.
  // Both happen only on the odd column, never in the same cycle.
  assign ram_addr  = col_c[POS_W-1:1];
  assign ram_wdata = {crs, cbs};
  assign ram_wr_en = accept && col_c[0] && !row_c[0];
  assign ram_rd_en = accept && col_c[0] && row_c[0];

  // Next state
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    held_nxt     = held_r;
    s1_item_nxt  = s1_item_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_take) s1_valid_nxt = 1'b0;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      if (!col_c[0]) held_nxt = {in_px.cr_in, in_px.cb_in};
      if (col_inc >= cfg.eff_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= cfg.eff_h) ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_nxt = col_inc[POS_W-1:0];
      end
      s1_item_nxt.row    = row_c;
      s1_item_nxt.col    = col_c;
      s1_item_nxt.luma   = in_px.luma_in;
      s1_item_nxt.cbs    = cbs;
      s1_item_nxt.crs    = crs;
      s1_item_nxt.chroma = col_c[0] && row_c[0];
      s1_item_nxt.layout = cfg.layout;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      held_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      held_r     <= held_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload stage, no reset
  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/ysub_emit.sv
// Result emitter: finishes the 2x2 averages and sends luma, then Cb and Cr.
// Depends on ysub_pkg and ysub_out_if.
`default_nettype none

module ysub_emit
  import ysub_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  wire item_t             s1_item,
  input  wire logic [PAIR_W-1:0] ram_rdata,
  output logic                   s1_take,
  ysub_out_if.source             out_res
);

  logic             em_valid_r, em_valid_nxt;
  logic [1:0]       step_r, step_nxt;
  item_t            it_r, it_nxt;
  logic [7:0]       u_r, u_nxt;
  logic [7:0]       v_r, v_nxt;

  logic             fire;
  logic             em_last;
  logic [SUM_W:0]   usum, vsum;
  logic [POS_W-1:0] crow, pair_col;

  assign fire    = out_res.valid && out_res.ready;
  assign em_last = !it_r.chroma || (step_r == STEP_CR);
  assign s1_take = s1_valid && (!em_valid_r || (fire && em_last));

  // Four-sample sums, truncated divide by four
  assign usum = {1'b0, s1_item.cbs} + {1'b0, ram_rdata[SUM_W-1:0]};
  assign vsum = {1'b0, s1_item.crs} + {1'b0, ram_rdata[PAIR_W-1:SUM_W]};

  always_comb begin
    em_valid_nxt = em_valid_r;
    step_nxt     = step_r;
    it_nxt       = it_r;
    u_nxt        = u_r;
    v_nxt        = v_r;
    if (fire) begin
      if (em_last) em_valid_nxt = 1'b0;
      else         step_nxt     = step_r + 2'd1;
    end
    if (s1_take) begin
      em_valid_nxt = 1'b1;
      step_nxt     = STEP_LUMA;
      it_nxt       = s1_item;
      u_nxt        = usum[SUM_W:2];
      v_nxt        = vsum[SUM_W:2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      step_r     <= STEP_LUMA;
    end else begin
      em_valid_r <= em_valid_nxt;
      step_r     <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r <= it_nxt;
    u_r  <= u_nxt;
    v_r  <= v_nxt;
  end

  // Result select
  assign crow     = {1'b0, it_r.row[POS_W-1:1]};
  assign pair_col = {1'b0, it_r.col[POS_W-1:1]};
  assign out_res.valid = em_valid_r;

  always_comb begin
    case (step_r)
      STEP_CB: begin
        out_res.plane      = PLANE_UV;
        out_res.out_row    = crow;
        out_res.out_column = (it_r.layout == LAYOUT_I420) ? pair_col
                                                         : {it_r.col[POS_W-1:1], 1'b0};
        out_res.sample     = u_r;
        out_res.last       = 1'b0;
      end
      STEP_CR: begin
        out_res.plane      = (it_r.layout == LAYOUT_I420) ? PLANE_V : PLANE_UV;
        out_res.out_row    = crow;
        out_res.out_column = (it_r.layout == LAYOUT_I420) ? pair_col : it_r.col;
        out_res.sample     = v_r;
        out_res.last       = 1'b1;
      end
      default: begin
        out_res.plane      = PLANE_Y;
        out_res.out_row    = it_r.row;
        out_res.out_column = it_r.col;
        out_res.sample     = it_r.luma;
        out_res.last       = !it_r.chroma;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/yuv444_to_420_subsampler.sv
// Top level of the 4:4:4 to 4:2:0 chroma subsampler.
// Depends on ysub_pkg, ysub_in_if, ysub_out_if, ysub_cfg, ysub_front, ysub_line_ram, ysub_emit.
`default_nettype none

// Takes packed 4:4:4 pixels in raster order and returns, per pixel, its luma
// byte, plus on the second pixel of each odd-row pair the Cb and Cr averages of
// the 2x2 block (NV12 interleaved or I420 separate planes). One pixel is
// accepted per clock while the result port keeps pace; results leave one per
// clock while the port is ready, so a pixel that closes a block holds the
// result port for three results. Each pixel is registered in the front stage
// and then in the emitter. The even-row pair sums live in a 2048 x 18
// single-port line store with a registered read; it is not cleared after
// reset, as each odd row only reads entries its even row has written.
module yuv444_to_420_subsampler
  import ysub_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  ysub_in_if.sink                in_px,
  ysub_out_if.source             out_res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t                cfg;
  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [LINE_AW-1:0]  ram_addr;
  logic [PAIR_W-1:0]   ram_wdata;
  logic [PAIR_W-1:0]   ram_rdata;
  logic                s1_valid;
  item_t               s1_item;
  logic                s1_take;

  ysub_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ysub_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_px     (in_px),
    .ram_wr_en (ram_wr_en),
    .ram_rd_en (ram_rd_en),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take)
  );

  ysub_line_ram #(
    .DW (PAIR_W),
    .AW (LINE_AW)
  ) u_line_ram (
    .clk   (clk),
    .wr_en (ram_wr_en),
    .rd_en (ram_rd_en),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ysub_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .ram_rdata (ram_rdata),
    .s1_take   (s1_take),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

### hw/rtl/ysub_chk.sv
// Port-level checker for the subsampler, bound to the top level.
// Depends on the top level's result channel only.
`default_nettype none

module ysub_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  plane,
  input wire logic [11:0] out_row,
  input wire logic [11:0] out_column,
  input wire logic [7:0]  sample,
  input wire logic        last
);

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(plane) && $stable(out_row)
      && $stable(out_column) && $stable(sample) && $stable(last))
    else $error("stalled result changed");

  // A V-plane byte always closes its pixel's results
  a_v_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && plane == 2'd2 |-> last)
    else $error("V plane result not marked last");

  // Luma that opens a chroma group is followed straight away by the Cb byte
  a_cb_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && plane == 2'd0 && !last |=> out_valid && plane == 2'd1 && !last)
    else $error("chroma group broken after luma");

  // Chroma rows cover half the frame
  a_chroma_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && plane != 2'd0 |-> !out_row[11])
    else $error("chroma row out of range");

endmodule

bind yuv444_to_420_subsampler ysub_chk u_ysub_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .plane      (out_res.plane),
  .out_row    (out_res.out_row),
  .out_column (out_res.out_column),
  .sample     (out_res.sample),
  .last       (out_res.last)
);

`default_nettype wire
